/* rtl/hld_pkg.sv */
// shared types, constants and register codes for the hard list viterbi decoder
// depends on nothing; imported by the top level, hld_cell and the sim files, not by hld_ram
`timescale 1ns / 1ps

package hld_pkg;

  localparam int MAX_STATES = 64;
  localparam int MAX_LIST   = 8;
  localparam int MAX_BLOCK  = 64;
  localparam int MAX_RATE   = 4;

  localparam int ST_W   = $clog2(MAX_STATES);
  localparam int RK_W   = $clog2(MAX_LIST);
  localparam int STEP_W = $clog2(MAX_BLOCK);
  localparam int MET_W  = 9;

  localparam logic [MET_W-1:0] METRIC_CAP = 9'd511;

  // configuration register indexes
  localparam logic [1:0] CFG_STATES = 2'd0;
  localparam logic [1:0] CFG_RATE   = 2'd1;
  localparam logic [1:0] CFG_LIST   = 2'd2;

  // item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [5:0] table_state;
    logic       table_bit;
    logic [5:0] table_next;
    logic [3:0] table_output;
    logic [3:0] code_bits;
    logic       end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  path_rank;
    logic [63:0] path_bits;
    logic [8:0]  path_metric;
    logic        path_valid;
    logic [6:0]  block_length;
    logic        last_path;
  } out_item_t;

  // one list entry: metric plus traceback data
  typedef struct packed {
    logic             ok;
    logic [MET_W-1:0] met;
    logic [ST_W-1:0]  prev;
    logic [RK_W-1:0]  rank;
    logic             in_bit;
  } entry_t;

  typedef struct packed {
    logic [ST_W-1:0] prev;
    logic [RK_W-1:0] rank;
    logic            in_bit;
  } tb_t;

  typedef entry_t [MAX_LIST-1:0] row_t;
  typedef tb_t    [MAX_LIST-1:0] tb_row_t;

  typedef struct packed {
    logic [ST_W-1:0] next;
    logic [3:0]      code;
  } trellis_t;

  typedef struct packed {
    logic load;
    logic ins;
  } cell_ctl_t;

endpackage

/* rtl/hard_list_viterbi_decoder_unit.sv */
// top level of the hard-decision list viterbi decoder
// depends on hld_pkg, hld_ram and hld_cell
`timescale 1ns / 1ps

// Items arrive on in_item with in_valid/in_stall. A load item (mode 0) writes one trellis
// entry and gives no result. A decode item (mode 1) runs one trellis step: every branch
// (state, bit) of the states in use is visited in order; for each branch the trellis
// entry is read, the target state's new list is read into a chain of MAX_LIST rank
// cells, the source state's list entries are inserted one per cycle, and the list is
// written back; a branch whose next state is out of use is skipped. The end-of-block
// item then traces back from state 0 through the traceback memory, one step at a time,
// for list_size paths, and each path may wait on out_stall.
// in_stall stays high while an item is worked on. Results leave through an output
// register, so the last result of a block may wait on out_stall while the next item
// starts. Lists use two ping-pong banks with one valid flag per row, so no clearing
// pass is needed after reset or between blocks.

module hard_list_viterbi_decoder_unit
  import hld_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_TR, S_NS, S_LD, S_INS, S_WB, S_ADV, S_FR, S_FL, S_PK, S_TA, S_TD, S_OUT
  } state_t;

  localparam int TB_D = MAX_BLOCK * MAX_STATES;

  state_t state_r;

  // configuration registers and their clamped values
  logic [6:0] cfg_states_r;
  logic [2:0] cfg_rate_r;
  logic [3:0] cfg_list_r;
  logic [6:0] s_use;
  logic [2:0] r_use;
  logic [3:0] l_use;

  // step control
  logic [ST_W-1:0]   cs_r;
  logic              b_r;
  logic [RK_W-1:0]   l_r;
  logic [ST_W-1:0]   ns_r;
  logic [2:0]        bm_r;
  logic [3:0]        rx_r;
  logic              eob_r;
  logic [STEP_W:0]   step_r;
  logic              cur_r;
  logic [MAX_STATES-1:0] fl_r [2];
  row_t              old_r;

  // traceback control
  logic [RK_W-1:0]   k_r;
  logic [STEP_W-1:0] i_r;
  logic [ST_W-1:0]   st_r;
  logic [RK_W-1:0]   rk_r;
  logic [63:0]       bits_r;

  out_item_t out_r;
  logic      out_valid_r;

  // memories
  trellis_t            tr_rd;
  logic [ST_W:0]       tr_waddr;
  logic                tr_we;
  row_t                bank_rd [2];
  logic [ST_W-1:0]     bank_raddr [2];
  logic                bank_we [2];
  row_t                old_rd;
  row_t                new_rd;
  logic [ST_W-1:0]     old_addr;
  tb_row_t             tb_wd;
  tb_row_t             tb_rd;

  // chain
  row_t                  cell_q;
  logic [MAX_LIST-1:0]   cell_cond;
  cell_ctl_t             cell_ctl;
  entry_t                cand;
  row_t                  load_row;
  logic [MET_W:0]        cand_sum;
  logic [3:0]            rx_mask;
  logic [3:0]            diff;
  logic [2:0]            bm;
  logic                  last_br;
  logic                  in_acc;
  logic                  out_free;
  row_t                  list_in;
  logic [ST_W-1:0]       list_state;

  // saturate registers into their ranges when used
  always_comb begin
    if (cfg_states_r < 7'd2) s_use = 7'd2;
    else if (cfg_states_r > 7'(MAX_STATES)) s_use = 7'(MAX_STATES);
    else s_use = cfg_states_r;
    if (cfg_rate_r < 3'd1) r_use = 3'd1;
    else if (cfg_rate_r > 3'(MAX_RATE)) r_use = 3'(MAX_RATE);
    else r_use = cfg_rate_r;
    if (cfg_list_r < 4'd1) l_use = 4'd1;
    else if (cfg_list_r > 4'(MAX_LIST)) l_use = 4'(MAX_LIST);
    else l_use = cfg_list_r;
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // trellis table, index state*2+bit
  assign tr_we    = in_acc && (in_item.mode == MODE_LOAD);
  assign tr_waddr = {in_item.table_state, in_item.table_bit};

  hld_ram #(.W($bits(trellis_t)), .D(2 * MAX_STATES)) u_trellis (
    .clk   (clk),
    .we    (tr_we),
    .waddr (tr_waddr),
    .wdata ({in_item.table_next, in_item.table_output}),
    .raddr ({cs_r, b_r}),
    .rdata (tr_rd)
  );

  // ping-pong list banks: cur_r holds the lists of the last step, the other one is built
  assign old_addr = (state_r == S_FR) ? '0 : cs_r;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      bank_raddr[j] = (cur_r == 1'(j)) ? old_addr : tr_rd.next;
      bank_we[j]    = (state_r == S_WB) && (cur_r != 1'(j));
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_bank
    hld_ram #(.W($bits(row_t)), .D(MAX_STATES)) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (ns_r),
      .wdata (cell_q),
      .raddr (bank_raddr[g]),
      .rdata (bank_rd[g])
    );
  end

  assign old_rd = bank_rd[cur_r];
  assign new_rd = bank_rd[!cur_r];

  // traceback store, one row of list entries per step and state
  always_comb begin
    for (int j = 0; j < MAX_LIST; j++) begin
      tb_wd[j] = '{prev: cell_q[j].prev, rank: cell_q[j].rank, in_bit: cell_q[j].in_bit};
    end
  end

  hld_ram #(.W($bits(tb_row_t)), .D(TB_D)) u_tb (
    .clk   (clk),
    .we    (state_r == S_WB),
    .waddr ({step_r[STEP_W-1:0], ns_r}),
    .wdata (tb_wd),
    .raddr ({i_r, st_r}),
    .rdata (tb_rd)
  );

  // branch metric
  assign rx_mask = 4'((5'd1 << r_use) - 5'd1);
  assign diff    = (rx_r ^ tr_rd.code) & rx_mask;
  assign bm      = 3'(diff[0]) + 3'(diff[1]) + 3'(diff[2]) + 3'(diff[3]);

  // candidate from the source list at rank l_r, metric saturated
  assign cand_sum = {1'b0, old_r[l_r].met} + {{(MET_W - 2){1'b0}}, bm_r};
  always_comb begin
    cand.ok     = 1'b1;
    cand.met    = (cand_sum > {1'b0, METRIC_CAP}) ? METRIC_CAP : cand_sum[MET_W-1:0];
    cand.prev   = cs_r;
    cand.rank   = l_r;
    cand.in_bit = b_r;
  end

  // target row: empty unless written in this step
  assign load_row = fl_r[!cur_r][ns_r] ? new_rd : '0;

  assign cell_ctl = '{load: (state_r == S_LD), ins: (state_r == S_INS) && old_r[l_r].ok};

  for (genvar g = 0; g < MAX_LIST; g++) begin : g_cell
    hld_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .en        (4'(g) < l_use),
      .load_data (load_row[g]),
      .cand      (cand),
      .left      ((g == 0) ? cand : cell_q[(g == 0) ? 0 : g - 1]),
      .left_cond ((g == 0) ? 1'b0 : cell_cond[(g == 0) ? 0 : g - 1]),
      .q         (cell_q[g]),
      .cond      (cell_cond[g])
    );
  end

  // source list: start of block has only state 0 rank 0 at metric zero
  assign list_state = (state_r == S_FL) ? '0 : cs_r;
  always_comb begin
    for (int j = 0; j < MAX_LIST; j++) begin
      if (step_r == '0) begin
        list_in[j]    = '0;
        list_in[j].ok = (j == 0) && (list_state == '0);
      end else if (fl_r[cur_r][list_state]) begin
        list_in[j] = old_rd[j];
      end else begin
        list_in[j] = '0;
      end
    end
  end

  assign last_br = ({1'b0, cs_r} == (s_use - 7'd1)) && b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_states_r <= 7'd64;
      cfg_rate_r   <= 3'd2;
      cfg_list_r   <= 4'd4;
      step_r       <= '0;
      cur_r        <= 1'b0;
      fl_r[0]      <= '0;
      fl_r[1]      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STATES: cfg_states_r <= cfg_data;
          CFG_RATE:   cfg_rate_r   <= cfg_data[2:0];
          CFG_LIST:   cfg_list_r   <= cfg_data[3:0];
          default: ;
        endcase
      end
      // result taken; S_OUT refills the register itself
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_item.mode == MODE_DECODE)) begin
            rx_r  <= in_item.code_bits;
            eob_r <= in_item.end_of_block;
            cs_r  <= '0;
            b_r   <= 1'b0;
            fl_r[!cur_r] <= '0;
            if (step_r < (STEP_W + 1)'(MAX_BLOCK)) begin
              state_r <= S_TR;
            end else if (in_item.end_of_block) begin
              state_r <= S_FR;
            end
          end
        end
        S_TR: state_r <= S_NS;
        S_NS: begin
          ns_r <= tr_rd.next;
          bm_r <= bm;
          // branches into states out of use are skipped
          state_r <= ({1'b0, tr_rd.next} >= s_use) ? S_ADV : S_LD;
        end
        S_LD: begin
          old_r   <= list_in;
          l_r     <= '0;
          state_r <= S_INS;
        end
        S_INS: begin
          if ({1'b0, l_r} == (l_use - 4'd1)) begin
            state_r <= S_WB;
          end else begin
            l_r <= l_r + 1'b1;
          end
        end
        S_WB: begin
          fl_r[!cur_r][ns_r] <= 1'b1;
          state_r <= S_ADV;
        end
        S_ADV: begin
          if (last_br) begin
            cur_r   <= !cur_r;
            step_r  <= step_r + 1'b1;
            state_r <= eob_r ? S_FR : S_IDLE;
          end else begin
            b_r     <= !b_r;
            if (b_r) cs_r <= cs_r + 1'b1;
            state_r <= S_TR;
          end
        end
        S_FR: begin
          k_r     <= '0;
          state_r <= S_FL;
        end
        S_FL: begin
          old_r   <= list_in;
          state_r <= S_PK;
        end
        S_PK: begin
          bits_r <= '0;
          i_r    <= 6'(step_r - 1'b1);
          st_r   <= '0;
          rk_r   <= k_r;
          state_r <= old_r[k_r].ok ? S_TA : S_OUT;
        end
        S_TA: state_r <= S_TD;
        S_TD: begin
          bits_r[i_r] <= tb_rd[rk_r].in_bit;
          st_r        <= tb_rd[rk_r].prev;
          rk_r        <= tb_rd[rk_r].rank;
          if (i_r == '0) begin
            state_r <= S_OUT;
          end else begin
            i_r     <= i_r - 1'b1;
            state_r <= S_TA;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_r.path_rank    <= k_r;
            out_r.path_valid   <= old_r[k_r].ok;
            out_r.path_bits    <= old_r[k_r].ok ? bits_r : '0;
            out_r.path_metric  <= old_r[k_r].ok ? old_r[k_r].met : '0;
            out_r.block_length <= step_r;
            out_r.last_path    <= ({1'b0, k_r} == (l_use - 4'd1));
            if ({1'b0, k_r} == (l_use - 4'd1)) begin
              step_r  <= '0;
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_PK;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // chain stays sorted: valid entries form a prefix with nondecreasing metrics
  function automatic logic chain_sorted(row_t r);
    logic good;
    good = 1'b1;
    for (int j = 1; j < MAX_LIST; j++) begin
      if (r[j].ok && (!r[j-1].ok || (r[j].met < r[j-1].met))) good = 1'b0;
    end
    return good;
  endfunction

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> chain_sorted(cell_q))
    else $error("insertion chain out of order");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.path_valid) |->
      (out_item.path_bits == '0) && (out_item.path_metric == '0))
    else $error("invalid path carries data");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= (STEP_W + 1)'(MAX_BLOCK))
    else $error("step count beyond block size");

  a_eob_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free && ({1'b0, k_r} == (l_use - 4'd1))) |=>
      (step_r == '0) && out_valid && out_item.last_path)
    else $error("block end not closed");

endmodule

/* rtl/hld_ram.sv */
// generic single write, single read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module hld_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/hld_cell.sv */
// one rank of the sorted insertion chain
// depends on hld_pkg
`timescale 1ns / 1ps

module hld_cell
  import hld_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      en,
  input  entry_t    load_data,
  input  entry_t    cand,
  input  entry_t    left,
  input  logic      left_cond,
  output entry_t    q,
  output logic      cond
);

  entry_t q_r;

  // candidate belongs at or before this rank
  assign cond = !q_r.ok || (cand.met < q_r.met);
  assign q    = q_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r <= en ? load_data : '0;
    end else if (ctl.ins && en) begin
      if (left_cond) begin
        q_r <= left;
      end else if (cond) begin
        q_r <= cand;
      end
    end
  end

endmodule

/* sim/hld_path_checker.sv */
// watches the item, result and register ports of the list viterbi decoder, predicts paths
// depends on hld_pkg; instantiated by tb_hard_list_viterbi_decoder_unit
`timescale 1ns / 1ps

module hld_path_checker
  import hld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  logic [5:0] trel_next [128];
  logic [3:0] trel_code [128];
  logic       surv_ok   [64][8];
  int         surv_met  [64][8];
  logic [5:0] hist_prev [64][64][8];
  logic [2:0] hist_rank [64][64][8];
  logic       hist_bit  [64][64][8];
  int         step_cnt;
  logic [6:0] reg_states;
  logic [2:0] reg_rate;
  logic [3:0] reg_list;
  out_item_t  path_q [$];
  int         errs;

  task automatic restart_lists();
    for (int s = 0; s < 64; s++)
      for (int k = 0; k < 8; k++) begin
        surv_ok[s][k] = 1'b0;
        surv_met[s][k] = 0;
      end
    surv_ok[0][0] = 1'b1;
    step_cnt = 0;
  endtask

  // one add-compare-select step over all branches, sorted insertion per target
  task automatic acs_step(input logic [3:0] rx, input int n_st, input int n_rate,
                          input int n_list);
    logic       nok  [64][8];
    int         nmet [64][8];
    logic [5:0] nprv [64][8];
    logic [2:0] nrnk [64][8];
    logic       nbit [64][8];
    logic [3:0] mask;
    int         ns, bm, cand;
    mask = 4'((1 << n_rate) - 1);
    for (int s = 0; s < 64; s++)
      for (int k = 0; k < 8; k++) begin
        nok[s][k] = 1'b0; nmet[s][k] = 0;
        nprv[s][k] = '0; nrnk[s][k] = '0; nbit[s][k] = 1'b0;
      end
    for (int cs = 0; cs < n_st; cs++)
      for (int b = 0; b < 2; b++) begin
        ns = trel_next[cs*2+b];
        bm = $countones((rx ^ trel_code[cs*2+b]) & mask);
        if (ns >= n_st) continue;
        for (int l = 0; l < n_list; l++) begin
          if (!surv_ok[cs][l]) continue;
          cand = surv_met[cs][l] + bm;
          if (cand > 511) cand = 511;
          for (int k = 0; k < n_list; k++) begin
            if (!nok[ns][k] || cand < nmet[ns][k]) begin
              for (int m = n_list - 1; m > k; m--) begin
                nok[ns][m] = nok[ns][m-1]; nmet[ns][m] = nmet[ns][m-1];
                nprv[ns][m] = nprv[ns][m-1]; nrnk[ns][m] = nrnk[ns][m-1];
                nbit[ns][m] = nbit[ns][m-1];
              end
              nok[ns][k] = 1'b1; nmet[ns][k] = cand;
              nprv[ns][k] = 6'(cs); nrnk[ns][k] = 3'(l); nbit[ns][k] = b[0];
              break;
            end
          end
        end
      end
    for (int s = 0; s < 64; s++)
      for (int k = 0; k < 8; k++) begin
        surv_ok[s][k] = nok[s][k];
        surv_met[s][k] = nmet[s][k];
        hist_prev[step_cnt][s][k] = nprv[s][k];
        hist_rank[step_cnt][s][k] = nrnk[s][k];
        hist_bit[step_cnt][s][k] = nbit[s][k];
      end
    step_cnt++;
  endtask

  task automatic take_item(input in_item_t it);
    int        n_st, n_rate, n_list, st, rk, nst;
    out_item_t p;
    n_st   = (reg_states < 2) ? 2 : (reg_states > 64) ? 64 : int'(reg_states);
    n_rate = (reg_rate < 1) ? 1 : (reg_rate > 4) ? 4 : int'(reg_rate);
    n_list = (reg_list < 1) ? 1 : (reg_list > 8) ? 8 : int'(reg_list);
    if (it.mode == MODE_LOAD) begin
      trel_next[{it.table_state, it.table_bit}] = it.table_next;
      trel_code[{it.table_state, it.table_bit}] = it.table_output;
      return;
    end
    if (step_cnt < MAX_BLOCK) acs_step(it.code_bits, n_st, n_rate, n_list);
    if (!it.end_of_block) return;
    for (int k = 0; k < n_list; k++) begin
      p = '0;
      p.path_rank = 3'(k);
      p.path_valid = surv_ok[0][k];
      p.block_length = 7'(step_cnt);
      p.last_path = (k == n_list - 1);
      if (surv_ok[0][k]) begin
        p.path_metric = 9'(surv_met[0][k]);
        st = 0; rk = k;
        for (int i = step_cnt - 1; i >= 0; i--) begin
          p.path_bits[i] = hist_bit[i][st][rk];
          nst = hist_prev[i][st][rk];
          rk = hist_rank[i][st][rk];
          st = nst;
        end
      end
      path_q.push_back(p);
    end
    restart_lists();
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      reg_states = 7'd64;
      reg_rate = 3'd2;
      reg_list = 4'd4;
      restart_lists();
      path_q.delete();
      errs = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STATES: reg_states = cfg_data;
          CFG_RATE:   reg_rate = cfg_data[2:0];
          CFG_LIST:   reg_list = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (path_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected path result rank %0d", out_item.path_rank);
        end else begin
          want = path_q.pop_front();
          if (want.path_rank !== out_item.path_rank ||
              want.path_bits !== out_item.path_bits ||
              want.path_metric !== out_item.path_metric ||
              want.path_valid !== out_item.path_valid ||
              want.block_length !== out_item.block_length ||
              want.last_path !== out_item.last_path) begin
            errs++;
            if (errs <= 10) begin
              $display("path mismatch: exp rank %0d bits %h met %0d ok %0d len %0d last %0d",
                want.path_rank, want.path_bits, want.path_metric, want.path_valid,
                want.block_length, want.last_path);
              $display("               got rank %0d bits %h met %0d ok %0d len %0d last %0d",
                out_item.path_rank, out_item.path_bits, out_item.path_metric,
                out_item.path_valid, out_item.block_length, out_item.last_path);
            end
          end
        end
      end
      if (in_valid && !in_stall) take_item(in_item);
    end
    fail_count <= errs;
    pending <= path_q.size();
  end

endmodule

/* sim/tb_hard_list_viterbi_decoder_unit.sv */
// testbench top for the hard list viterbi decoder: stimulus, receiver stalls and verdict
// depends on hld_pkg, hard_list_viterbi_decoder_unit and hld_path_checker
`timescale 1ns / 1ps

module tb_hard_list_viterbi_decoder_unit;
  import hld_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_STATES;
  logic [6:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         cyc = 0;
  int         burst_left = 0;

  hard_list_viterbi_decoder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hld_path_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("hard_list_viterbi_decoder_unit test failed");
      $finish;
    end
  end

  // receiver: a randomly picked stall style, plus two long hold-offs
  // while the sender keeps offering, so the block backs up into its input
  always @(posedge clk) begin
    int rx_cyc, hold_left, stall_style;
    rx_cyc++;
    if (rx_cyc % 300 == 0) stall_style = $urandom_range(0, 3);
    if (rx_cyc == 4000 || rx_cyc == 40000) hold_left = 3000;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= rx_cyc[0];
      endcase
    end
  end

  // offer one item and hold it until taken; valid stays up inside a burst
  task automatic send(input in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic load_entry(input int st, input int b, input int nxt, input int code);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.mode = MODE_LOAD;
    it.table_state = 6'(st);
    it.table_bit = 1'(b);
    it.table_next = 6'(nxt);
    it.table_output = 4'(code);
    send(it);
  endtask

  task automatic decode_sym(input int code, input bit last);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.mode = MODE_DECODE;
    it.code_bits = 4'(code);
    it.end_of_block = last;
    send(it);
  endtask

  // wait until every path is out and the block is idle before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || in_stall || out_valid) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_regs(input int sr, input int rr, input int lr);
    cfg_we <= 1'b1;
    cfg_index <= CFG_STATES; cfg_data <= 7'(sr);
    @(posedge clk);
    cfg_index <= CFG_RATE; cfg_data <= 7'(rr);
    @(posedge clk);
    cfg_index <= CFG_LIST; cfg_data <= 7'(lr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one register setting: fill the trellis for the states in use, then blocks of symbols
  task automatic run_phase(input int sr, input int rr, input int lr, input int n_sym,
                           input bit long_block);
    int n_st, len, left;
    n_st = (sr < 2) ? 2 : (sr > 64) ? 64 : sr;
    settle();
    set_regs(sr, rr, lr);
    for (int s = 0; s < n_st; s++)
      for (int b = 0; b < 2; b++)
        load_entry(s, b, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, n_st - 1),
                   $urandom_range(0, 15));
    if (long_block) begin
      // block full: symbols past the block size are dropped, mark still ends it
      for (int j = 0; j < 70; j++) decode_sym($urandom_range(0, 15), j == 69);
      left = n_sym - 70;
    end else begin
      left = n_sym;
    end
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 9) == 0)
          load_entry($urandom_range(0, n_st - 1), $urandom_range(0, 1),
                     $urandom_range(0, 63), $urandom_range(0, 15));
        decode_sym($urandom_range(0, 15), j == len - 1);
      end
      left -= len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 4 states, widest symbols, longest list; ties into state 0,
    // an out-of-use next state and all-zero / all-one symbols
    set_regs(4, 4, 8);
    load_entry(0, 0, 0, 0);
    load_entry(0, 1, 1, 0);
    load_entry(1, 0, 2, 15);
    load_entry(1, 1, 3, 15);
    load_entry(2, 0, 0, 15);
    load_entry(2, 1, 63, 0);
    load_entry(3, 0, 0, 15);
    load_entry(3, 1, 2, 15);
    decode_sym(15, 1'b0);
    decode_sym(0, 1'b0);
    decode_sym(5, 1'b1);
    decode_sym(15, 1'b1);
    begin
      in_item_t it;
      it = '0;
      it.mode = MODE_LOAD;
      it.table_state = 6'd63;
      it.table_bit = 1'b1;
      it.table_next = 6'd63;
      it.table_output = 4'd15;
      it.end_of_block = 1'b1;
      send(it);
    end
    decode_sym(0, 1'b0);
    decode_sym(10, 1'b0);
    decode_sym(0, 1'b1);

    // random settings, raw values past both ends of each range included
    run_phase(0, 0, 0, 45, 1'b0);
    run_phase(3, 1, 15, 45, 1'b0);
    run_phase(8, 4, 8, 45, 1'b0);
    run_phase(5, 7, 3, 30, 1'b0);
    run_phase(6, 2, 2, 30, 1'b0);
    run_phase(2, 4, 1, 80, 1'b1);
    run_phase(127, 3, 8, 6, 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("hard_list_viterbi_decoder_unit test passed");
    end else begin
      $display("hard_list_viterbi_decoder_unit test failed");
    end
    $finish;
  end

endmodule
